FILE: rtl/core/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types and constants for the HTTP request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    // Parse phase codes
    localparam logic [1:0] PH_METHOD  = 2'd0;
    localparam logic [1:0] PH_PATH    = 2'd1;
    localparam logic [1:0] PH_QUERY   = 2'd2;
    localparam logic [1:0] PH_VERSION = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_METHOD = 2'd0;
    localparam logic [1:0] KIND_PATH   = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Final status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_BAD_VER   = 2'd2;
    localparam logic [1:0] ST_BAD_PATH  = 2'd3;

    // Character constants
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam int          PREFIX_LEN = 5;
    localparam logic [2:0]  PREFIX_END = 3'(PREFIX_LEN);
    localparam logic [15:0] VER_LIMIT  = 16'hFFFF;
    localparam logic [15:0] VER_09_MINOR = 16'd9;

    // "HTTP/" in order
    localparam logic [7:0] VER_PREFIX [PREFIX_LEN] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F};

    typedef struct packed {
        logic [1:0]  phase;
        logic [1:0]  hex_left;
        logic [7:0]  hex_accum;
        logic        path_stopped;
        logic        path_started;
        logic        path_slash_first;
        logic [2:0]  prefix_index;
        logic        in_minor;
        logic [15:0] major_accum;
        logic [15:0] minor_accum;
        logic        version_bad;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_out;
        logic [1:0]  status;
        logic [15:0] major_version;
        logic [15:0] minor_version;
        logic        final_res;
    } result_t;

endpackage

FILE: rtl/core/hrlp_parse_step.sv
// ----------------------------------------------------------------------------
// hrlp_parse_step
// Next-state and result logic for one request line byte or terminator.
// ----------------------------------------------------------------------------
module hrlp_parse_step (
    input  hrlp_pkg::parse_state_t cur,
    input  logic [7:0]             char_in,
    input  logic                   end_of_line,
    output hrlp_pkg::parse_state_t nxt,
    output logic                   emit,
    output hrlp_pkg::result_t      res
);
    import hrlp_pkg::*;

    logic       hex_ok;
    logic [7:0] hex_d;

    // hex digit decode
    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 8'd0;
        if (char_in >= 8'h30 && char_in <= 8'h39)
        begin
            hex_d = char_in - 8'h30;
        end
        else if (char_in >= 8'h41 && char_in <= 8'h46)
        begin
            hex_d = char_in - 8'h37;
        end
        else if (char_in >= 8'h61 && char_in <= 8'h66)
        begin
            hex_d = char_in - 8'h57;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        logic        have;
        logic [7:0]  val;
        logic [7:0]  sum;
        logic [15:0] acc;
        logic [19:0] v;
        logic [1:0]  st;

        nxt  = cur;
        emit = 1'b0;
        res  = '0;
        have = 1'b0;
        val  = char_in;
        sum  = cur.hex_accum + hex_d;
        acc  = cur.in_minor ? cur.minor_accum : cur.major_accum;
        v    = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {12'd0, char_in - CH_ZERO};
        st   = ST_OK;

        if (end_of_line)
        begin
            res.kind      = KIND_STATUS;
            res.final_res = 1'b1;
            if (cur.phase == PH_METHOD)
            begin
                st = ST_NO_SPACE;
            end
            else
            begin
                if (cur.phase == PH_VERSION)
                begin
                    if (cur.version_bad || cur.prefix_index < PREFIX_END || !cur.in_minor)
                    begin
                        st = ST_BAD_VER;
                    end
                    else
                    begin
                        res.major_version = cur.major_accum;
                        res.minor_version = cur.minor_accum;
                    end
                end
                else
                begin
                    res.minor_version = VER_09_MINOR;
                end
                if (st == ST_OK && !(cur.path_started && cur.path_slash_first))
                begin
                    st = ST_BAD_PATH;
                end
            end
            res.status = st;
            emit       = 1'b1;
            nxt        = '0;
        end
        else
        begin
            unique case (cur.phase)
                PH_METHOD:
                begin
                    if (char_in == CH_SPACE)
                    begin
                        nxt.phase = PH_PATH;
                    end
                    else
                    begin
                        emit          = 1'b1;
                        res.kind      = KIND_METHOD;
                        res.char_out  = char_in;
                    end
                end
                PH_PATH:
                begin
                    if (char_in == CH_SPACE)
                    begin
                        nxt.phase = PH_VERSION;
                    end
                    else if (char_in == CH_QUEST)
                    begin
                        nxt.phase = PH_QUERY;
                    end
                    else if (!cur.path_stopped)
                    begin
                        if (char_in == CH_PERCENT)
                        begin
                            nxt.hex_left  = 2'd2;
                            nxt.hex_accum = 8'd0;
                        end
                        else if (cur.hex_left == 2'd0)
                        begin
                            have = 1'b1;
                        end
                        else if (!hex_ok)
                        begin
                            nxt.path_stopped = 1'b1;
                        end
                        else if (cur.hex_left == 2'd2)
                        begin
                            nxt.hex_accum = {hex_d[3:0], 4'h0};
                            nxt.hex_left  = 2'd1;
                        end
                        else
                        begin
                            nxt.hex_accum = sum;
                            nxt.hex_left  = 2'd0;
                            val           = sum;
                            have          = 1'b1;
                        end
                        if (have)
                        begin
                            if (val == 8'd0)
                            begin
                                nxt.path_stopped = 1'b1;
                            end
                            else
                            begin
                                if (!cur.path_started)
                                begin
                                    nxt.path_started     = 1'b1;
                                    nxt.path_slash_first = (val == CH_SLASH);
                                end
                                emit         = 1'b1;
                                res.kind     = KIND_PATH;
                                res.char_out = val;
                            end
                        end
                    end
                end
                PH_QUERY:
                begin
                    if (char_in == CH_SPACE)
                    begin
                        nxt.phase = PH_VERSION;
                    end
                    else
                    begin
                        emit         = 1'b1;
                        res.kind     = KIND_QUERY;
                        res.char_out = char_in;
                    end
                end
                PH_VERSION:
                begin
                    if (!cur.version_bad)
                    begin
                        if (cur.prefix_index < PREFIX_END)
                        begin
                            if (char_in != VER_PREFIX[cur.prefix_index])
                            begin
                                nxt.version_bad = 1'b1;
                            end
                            else
                            begin
                                nxt.prefix_index = cur.prefix_index + 3'd1;
                            end
                        end
                        else if (char_in == CH_DOT)
                        begin
                            if (cur.in_minor)
                            begin
                                nxt.version_bad = 1'b1;
                            end
                            else
                            begin
                                nxt.in_minor = 1'b1;
                            end
                        end
                        else if (char_in < CH_ZERO || char_in > CH_NINE)
                        begin
                            nxt.version_bad = 1'b1;
                        end
                        else
                        begin
                            // saturate at the limit and flag it
                            if (v >= {4'd0, VER_LIMIT})
                            begin
                                v               = {4'd0, VER_LIMIT};
                                nxt.version_bad = 1'b1;
                            end
                            if (cur.in_minor)
                            begin
                                nxt.minor_accum = v[15:0];
                            end
                            else
                            begin
                                nxt.major_accum = v[15:0];
                            end
                        end
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/hrlp_out_reg.sv
// ----------------------------------------------------------------------------
// hrlp_out_reg
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
module hrlp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hrlp_pkg::result_t res_in,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              can_load,
    output hrlp_pkg::result_t res_out
);
    import hrlp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // free when empty or draining this cycle
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

FILE: rtl/core/http_request_line_parser_top.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_top
// Streaming HTTP request line parser with percent-decoded path output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one byte per transaction in
//   char_in; a transaction with end_of_line set closes the line.
//   Output channel (out_valid/out_ready) carries method, decoded path and
//   query bytes, and one final status transaction per line (final_res=1).
//   Bytes that only advance parsing (spaces, '?', '%', escape digits,
//   version text) produce no output transaction.
// Timing:
//   One input transaction per cycle sustained while no result is held
//   stalled. A result appears in the cycle after its input is accepted:
//   the parse state and the result register both load on the accept edge,
//   with only the per-byte update logic in between.
// Reset:
//   rst_n clears the parse state to the method phase and empties the
//   result register; the block is ready in the first cycle after reset.
// Stall:
//   While a result waits and out_ready is low, in_ready drops; the held
//   result stays stable. When out_ready is high the register drains and
//   refills in the same cycle, so no bubble is inserted.
// ----------------------------------------------------------------------------
module http_request_line_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  char_out,
    output logic [1:0]  status,
    output logic [15:0] major_version,
    output logic [15:0] minor_version,
    output logic        final_res
);
    import hrlp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_res;
    result_t      held_res;
    logic         step_emit;
    logic         accept;
    logic         can_load;

    assign in_ready = can_load;
    assign accept   = in_valid && can_load;

    // per-byte update of the running parse state
    hrlp_parse_step u_step (
        .cur         (state_reg),
        .char_in     (char_in),
        .end_of_line (end_of_line),
        .nxt         (state_next),
        .emit        (step_emit),
        .res         (step_res)
    );

    // state advances on every accepted transaction; terminator clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    hrlp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && step_emit),
        .res_in    (step_res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .res_out   (held_res)
    );

    assign kind          = held_res.kind;
    assign char_out      = held_res.char_out;
    assign status        = held_res.status;
    assign major_version = held_res.major_version;
    assign minor_version = held_res.minor_version;
    assign final_res     = held_res.final_res;

endmodule

FILE: rtl/core/hrlp_checker.sv
// ----------------------------------------------------------------------------
// hrlp_checker
// Port-level checks for the request line parser, bound to the top level.
// ----------------------------------------------------------------------------
module hrlp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  char_in,
    input logic        end_of_line,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  char_out,
    input logic [1:0]  status,
    input logic [15:0] major_version,
    input logic [15:0] minor_version,
    input logic        final_res
);
    import hrlp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_out)
            && $stable(status) && $stable(final_res))
        else $error("stalled result changed");

    // an empty output register never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result register");

    // final flag marks exactly the status kind
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (final_res == (kind == KIND_STATUS)))
        else $error("final_res and kind disagree");

    // byte results carry no status or version
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_STATUS |->
            status == ST_OK && major_version == 16'd0 && minor_version == 16'd0)
        else $error("byte result with status fields set");

    // lines failing on no space or a bad version report no version
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_res && (status == ST_NO_SPACE || status == ST_BAD_VER) |->
            major_version == 16'd0 && minor_version == 16'd0)
        else $error("version reported on failed line");

endmodule

bind http_request_line_parser_top hrlp_checker u_hrlp_checker (.*);

FILE: sim/http_request_line_parser_top_test.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_top_test
// Self-checking bench for the request line parser: a queue of byte
// transactions drives the input channel, a per-transaction predictor tracks
// the parse state, and every output transaction is checked in order.
// ----------------------------------------------------------------------------
module http_request_line_parser_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hrlp_pkg::*;

    // Generous bound: ~1600 transactions, each at worst a long input gap
    // plus a long output stall, with several times that as margin.
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned HEX_RADIX = 16;
    localparam logic [39:0] HTTP_TAG = "HTTP/";

    typedef struct {
        logic [7:0]  ch;
        logic        eol;
        int unsigned gap;     // idle cycles after this transaction
    } line_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_in = 8'h00;
    logic        end_of_line = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  char_out;
    logic [1:0]  status;
    logic [15:0] major_version;
    logic [15:0] minor_version;
    logic        final_res;

    http_request_line_parser_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_in       (char_in),
        .end_of_line   (end_of_line),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .char_out      (char_out),
        .status        (status),
        .major_version (major_version),
        .minor_version (minor_version),
        .final_res     (final_res)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parse state
    // ------------------------------------------------------------------
    logic [1:0]  ps_phase;
    logic [1:0]  ps_hex_left;
    logic [7:0]  ps_hex_acc;
    logic        ps_path_stopped;
    logic        ps_path_started;
    logic        ps_slash_first;
    logic [2:0]  ps_prefix_idx;
    logic        ps_in_minor;
    logic [15:0] ps_major;
    logic [15:0] ps_minor;
    logic        ps_ver_bad;

    line_item_t  pending_items[$];
    result_t     expected_results[$];
    int unsigned mismatches = 0;
    bit          line_quiet = 1'b0;   // whole line sent back to back

    function automatic void clear_parse_state();
        ps_phase        = PH_METHOD;
        ps_hex_left     = 2'd0;
        ps_hex_acc      = 8'h00;
        ps_path_stopped = 1'b0;
        ps_path_started = 1'b0;
        ps_slash_first  = 1'b0;
        ps_prefix_idx   = 3'd0;
        ps_in_minor     = 1'b0;
        ps_major        = 16'd0;
        ps_minor        = 16'd0;
        ps_ver_bad      = 1'b0;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    // Advances the predicted parse state by one transaction; returns 1 and
    // fills r when that transaction produces an output transaction.
    function automatic bit parse_byte(input logic [7:0] c, input logic eol,
                                      output result_t r);
        int         d;
        int         v;
        logic [7:0] emit;
        bit         have;
        r = '0;
        if (eol) begin
            r.kind = KIND_STATUS;
            r.final_res = 1'b1;
            if (ps_phase == PH_METHOD) begin
                r.status = ST_NO_SPACE;
            end
            else if (ps_phase == PH_VERSION) begin
                if (ps_ver_bad || ps_prefix_idx < PREFIX_END || !ps_in_minor) begin
                    r.status = ST_BAD_VER;
                end
                else begin
                    r.status = ST_OK;
                    r.major_version = ps_major;
                    r.minor_version = ps_minor;
                end
            end
            else begin
                // no second space: a 0.9 request
                r.status = ST_OK;
                r.minor_version = VER_09_MINOR;
            end
            // version numbers stay on a bad-path status
            if (r.status == ST_OK && !(ps_path_started && ps_slash_first))
                r.status = ST_BAD_PATH;
            clear_parse_state();
            return 1'b1;
        end
        case (ps_phase)
            PH_METHOD:
            begin
                if (c == CH_SPACE) begin
                    ps_phase = PH_PATH;
                    return 1'b0;
                end
                r.kind = KIND_METHOD;
                r.char_out = c;
                return 1'b1;
            end
            PH_PATH:
            begin
                if (c == CH_SPACE) begin
                    ps_phase = PH_VERSION;
                    return 1'b0;
                end
                if (c == CH_QUEST) begin
                    ps_phase = PH_QUERY;
                    return 1'b0;
                end
                if (ps_path_stopped) return 1'b0;
                if (c == CH_PERCENT) begin
                    ps_hex_left = 2'd2;
                    ps_hex_acc = 8'h00;
                    return 1'b0;
                end
                emit = c;
                have = 1'b1;
                if (ps_hex_left != 2'd0) begin
                    d = hex_digit(c);
                    if (d < 0) begin
                        ps_path_stopped = 1'b1;
                        have = 1'b0;
                    end
                    else if (ps_hex_left == 2'd2) begin
                        ps_hex_acc = 8'(d * HEX_RADIX);
                        ps_hex_left = 2'd1;
                        have = 1'b0;
                    end
                    else begin
                        ps_hex_acc = ps_hex_acc + 8'(d);
                        ps_hex_left = 2'd0;
                        emit = ps_hex_acc;
                    end
                end
                if (have && emit == 8'h00) begin
                    ps_path_stopped = 1'b1;
                    have = 1'b0;
                end
                if (!have) return 1'b0;
                if (!ps_path_started) begin
                    ps_path_started = 1'b1;
                    ps_slash_first = (emit == CH_SLASH);
                end
                r.kind = KIND_PATH;
                r.char_out = emit;
                return 1'b1;
            end
            PH_QUERY:
            begin
                if (c == CH_SPACE) begin
                    ps_phase = PH_VERSION;
                    return 1'b0;
                end
                r.kind = KIND_QUERY;
                r.char_out = c;
                return 1'b1;
            end
            default:
            begin
                if (ps_ver_bad) return 1'b0;
                if (ps_prefix_idx < PREFIX_END) begin
                    if (c != HTTP_TAG[8 * (4 - int'(ps_prefix_idx)) +: 8])
                        ps_ver_bad = 1'b1;
                    else
                        ps_prefix_idx = ps_prefix_idx + 3'd1;
                end
                else if (c == CH_DOT) begin
                    if (ps_in_minor) ps_ver_bad = 1'b1;
                    else ps_in_minor = 1'b1;
                end
                else if (c < CH_ZERO || c > CH_NINE) begin
                    ps_ver_bad = 1'b1;
                end
                else begin
                    v = int'(ps_in_minor ? ps_minor : ps_major) * 10 + int'(c - CH_ZERO);
                    if (v >= int'(VER_LIMIT)) begin
                        v = int'(VER_LIMIT);
                        ps_ver_bad = 1'b1;
                    end
                    if (ps_in_minor) ps_minor = 16'(v);
                    else ps_major = 16'(v);
                end
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_byte(input logic [7:0] ch);
        line_item_t it;
        it.ch = ch;
        it.eol = 1'b0;
        it.gap = line_quiet ? 0 : idle_len();
        pending_items.push_back(it);
    endtask

    // Terminator: char_in is don't-care, so it carries random bits.
    task automatic push_eol();
        line_item_t it;
        it.ch = 8'($urandom_range(0, 255));
        it.eol = 1'b1;
        it.gap = line_quiet ? 0 : idle_len();
        pending_items.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_line(input string s);
        push_text(s);
        push_eol();
    endtask

    function automatic logic [7:0] rand_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) return CH_ZERO + 8'(v);
        if ($urandom_range(0, 1) != 0) return "A" + 8'(v - 10);
        return "a" + 8'(v - 10);
    endfunction

    // Decimal digit run; long runs drive the saturation path.
    task automatic push_number();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 10) n = 0;
        else if (r < 65) n = 1;
        else if (r < 85) n = $urandom_range(2, 3);
        else n = $urandom_range(4, 6);
        for (int i = 0; i < n; i++) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_random_line();
        string       path_chars;
        string       tag;
        int unsigned r;
        int unsigned n;
        logic [7:0]  b;
        path_chars = "abcdefghijklmnopqrstuvwxyz0123456789/._-~ABZ";
        line_quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 2) begin
            // noise: random bytes with spaces sprinkled in
            n = $urandom_range(0, 30);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 6) == 0) push_byte(CH_SPACE);
                else push_byte(8'($urandom_range(0, 255)));
            end
            push_eol();
            return;
        end
        // method
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                b = 8'($urandom_range(0, 255));
                push_byte(b == CH_SPACE ? 8'hFF : b);
            end
            else begin
                push_byte("A" + 8'($urandom_range(0, 25)));
            end
        end
        if ($urandom_range(0, 29) == 0) begin
            push_eol();
            return;
        end
        push_byte(CH_SPACE);
        // path
        r = $urandom_range(0, 19);
        if (r < 16) push_byte(CH_SLASH);
        else if (r < 18) push_text("%2F");
        else if (r == 18) push_byte(path_chars[$urandom_range(0, path_chars.len() - 1)]);
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                push_byte(path_chars[$urandom_range(0, path_chars.len() - 1)]);
            end
            else if (r < 80) begin
                push_byte(CH_PERCENT);
                push_byte(rand_hex_char());
                push_byte(rand_hex_char());
            end
            else if (r < 85) begin
                push_byte(CH_PERCENT);
                if ($urandom_range(0, 1) != 0) push_byte(rand_hex_char());
                push_byte("g" + 8'($urandom_range(0, 19)));
            end
            else if (r < 90) begin
                // escape cut short after a single hex digit
                push_byte(CH_PERCENT);
                push_byte(rand_hex_char());
            end
            else if (r < 93) begin
                push_byte(8'h00);
            end
            else begin
                b = 8'($urandom_range(0, 255));
                push_byte((b == CH_SPACE || b == CH_QUEST) ? 8'h80 : b);
            end
        end
        // query
        if ($urandom_range(0, 9) < 4) begin
            push_byte(CH_QUEST);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom_range(0, 255));
                push_byte(b == CH_SPACE ? "+" : b);
            end
        end
        // version, left out for a 0.9 request
        if ($urandom_range(0, 19) < 17) begin
            push_byte(CH_SPACE);
            tag = "HTTP/";
            if ($urandom_range(0, 9) == 0)
                tag[$urandom_range(0, 4)] = "A" + 8'($urandom_range(0, 25));
            push_text(tag);
            push_number();
            if ($urandom_range(0, 9) != 0) push_byte(CH_DOT);
            push_number();
            r = $urandom_range(0, 19);
            if (r == 0) push_byte(CH_DOT);
            else if (r == 1) push_byte(CH_SPACE);
            else if (r == 2) push_byte(8'($urandom_range(0, 255)));
        end
        push_eol();
    endtask

    task automatic add_directed_lines();
        line_quiet = 1'b0;
        push_line("GET /index.html HTTP/1.1");
        push_line("POST /a%41%6a?x=%41&y HTTP/65534.65534");
        push_line("PUT %2Fb%4%41c HTTP/0.0");          // decoded slash, escape restart
        push_line("GET /a%G1bc%41 HTTP/1.1");          // non-hex stops path output
        push_line("GET /a%00bc HTTP/1.1");             // decoded zero stops path output
        push_text("GET /a");                           // raw zero in path
        push_byte(8'h00);
        push_line("bc HTTP/1.1");
        push_text("G");                                // zero in method, query, version
        push_byte(8'h00);
        push_text("T /q?");
        push_byte(8'h00);
        push_text("z HTTP/1.");
        push_byte(8'h00);
        push_eol();
        push_line("GET /p%4?q HTTP/1.1");              // escape cut by '?'
        push_line("GET /p%4 HTTP/1.1");                // escape cut by space
        push_line("GET /p%4");                         // escape cut by the terminator
        push_line("GET  HTTP/1.1");                    // empty path
        push_line("GET ?a HTTP/1.1");
        push_line("GETX");                             // no space
        push_eol();
        push_line("GET /x");                           // 0.9 request
        push_line("GET x");
        push_line("GET / HTTP/.");                     // empty major and minor
        push_line("GET / HTTP/1");
        push_line("GET / HTTP/1.2.3");
        push_line("GET / HTTP/65535.0");
        push_line("GET / HTTP/1.99999");
        push_line("GET / HTPP/1.1");
        push_line("GET / HTTP/1.1 ");
        push_line("GET x HTTP/x");                     // bad version beats bad path
        push_line("GET x HTTP/1.1");
        line_quiet = 1'b1;
        push_byte(8'hFF);                              // top byte in method, path and query
        push_text(" /");
        push_byte(8'hFF);
        push_byte(CH_QUEST);
        push_byte(8'hFF);
        push_line(" HTTP/9.9");
    endtask

    // ------------------------------------------------------------------
    // Input driver: pops the pending queue, holds each transaction until
    // accepted, then idles for that transaction's gap.
    // ------------------------------------------------------------------
    int unsigned idle_left = 0;
    line_item_t  next_item;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            idle_left <= 0;
        end
        else if (!in_valid || in_ready) begin
            if (idle_left != 0) begin
                in_valid <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                in_valid <= 1'b1;
                char_in <= next_item.ch;
                end_of_line <= next_item.eol;
                idle_left <= next_item.gap;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output backpressure: random stalls, with quiet stretches that
    // toggle at random.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    bit          rx_quiet = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else begin
            if ($urandom_range(0, 511) == 0) rx_quiet <= !rx_quiet;
            if (stall_left != 0) begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else begin
                out_ready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 2) == 0) stall_left <= idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks the output transaction against the oldest
    // expectation, then runs the predictor on any accepted input.
    // ------------------------------------------------------------------
    result_t predicted;
    result_t oldest;

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("output transaction with nothing expected: kind %0d char %0h",
                           kind, char_out);
                    mismatches++;
                end
                else begin
                    oldest = expected_results.pop_front();
                    check_field("kind", oldest.kind, kind);
                    check_field("char_out", oldest.char_out, char_out);
                    check_field("status", oldest.status, status);
                    check_field("major_version", oldest.major_version, major_version);
                    check_field("minor_version", oldest.minor_version, minor_version);
                    check_field("final_res", oldest.final_res, final_res);
                end
            end
            if (in_valid && in_ready) begin
                if (parse_byte(char_in, end_of_line, predicted))
                    expected_results.push_back(predicted);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int unsigned cycle_count = 0;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("http_request_line_parser_top_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: build all stimulus, release reset, drain, report.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned target;
        clear_parse_state();
        add_directed_lines();
        target = RANDOM_ITEMS;
        while (pending_items.size() < target) add_random_line();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // all input accepted and every expected transaction seen
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        // a short tail catches stray outputs
        repeat (8) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("http_request_line_parser_top_test passed");
        else
            $display("http_request_line_parser_top_test failed");
        $finish;
    end

endmodule
